@@ sv/rfc_pkg.sv @@
package rfc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int HEADER_DEPTH        = 6;
    localparam int CFG_INDEX_W         = 2;

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PREAMBLE = 2'd0,
        REG_TAG_CMD  = 2'd1,
        REG_VER_CMD  = 2'd2,
        REG_SIZE_OFS = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SIZE     = 3'd1,
        ST_PREAMBLE = 3'd2,
        ST_COMMAND  = 3'd3,
        ST_CRC      = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] preamble_code;
        logic [7:0] tag_command_code;
        logic [7:0] version_command_code;
        logic [7:0] size_offset;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] cmd_code;
        logic [7:0] uid_length;
        logic [7:0] tag_value;
        logic [7:0] sensor_value;
        logic [7:0] sensor_mask;
    } t_result;

    // Reflected CRC-8, one byte, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ data[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/rfc_frame_core.sv @@
module rfc_frame_core #(
    parameter int MAX_FRAME_BYTES = rfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  rfc_pkg::t_cfg    i_cfg,
    output rfc_pkg::t_result o_result
);
    import rfc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_FRAME_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_crc;
    logic [7:0]    r_hdr [HEADER_DEPTH];
    logic [7:0]    h_eff [HEADER_DEPTH];
    logic [7:0]    r_mask, n_mask;
    logic [8:0]    size_sum;
    t_status       status;

    // Header view including the byte now being taken, so a short frame sees
    // its own final byte.
    always_comb begin
        for (int k = 0; k < HEADER_DEPTH; k++) begin
            h_eff[k] = (r_count == CW'(k)) ? i_byte : r_hdr[k];
        end
    end

    always_comb begin
        if (r_count >= COUNT_MAX) begin
            n_count = r_count;
            n_ovf   = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
            n_ovf   = r_ovf;
        end
    end

    assign size_sum = {1'b0, h_eff[1]} + {1'b0, i_cfg.size_offset};

    always_comb begin
        if (n_ovf || (9'(n_count) != size_sum)) begin
            status = ST_SIZE;
        end else if (h_eff[0] != i_cfg.preamble_code) begin
            status = ST_PREAMBLE;
        end else if (h_eff[2] != i_cfg.tag_command_code &&
                     h_eff[2] != i_cfg.version_command_code) begin
            status = ST_COMMAND;
        end else if (i_byte != r_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    assign n_mask = (status == ST_OK) ? (r_mask | {h_eff[5][3:0], 4'h0}) : r_mask;

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.cmd_code     = h_eff[2];
            o_result.uid_length   = h_eff[3];
            o_result.tag_value    = h_eff[4];
            o_result.sensor_value = h_eff[5];
        end
        o_result.sensor_mask = n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_crc   <= CRC_INIT;
            r_mask  <= '0;
            for (int k = 0; k < HEADER_DEPTH; k++) begin
                r_hdr[k] <= '0;
            end
        end else if (i_step) begin
            if (i_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_crc   <= CRC_INIT;
                r_mask  <= n_mask;
                for (int k = 0; k < HEADER_DEPTH; k++) begin
                    r_hdr[k] <= '0;
                end
            end else begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
                r_crc   <= crc8_byte(r_crc, i_byte);
                for (int k = 0; k < HEADER_DEPTH; k++) begin
                    r_hdr[k] <= h_eff[k];
                end
            end
        end
    end

endmodule

@@ sv/rfc_out_reg.sv @@
module rfc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rfc_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output rfc_pkg::t_result o_result
);
    import rfc_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

@@ sv/rfid_reply_frame_checker_top.sv @@
// A result is valid once the final byte has passed the input register and the result
// register. Throughput: one byte per cycle, held only while a final byte waits on a full,
// stalled result register; the CRC update and the verdict compares sit in one stage between the two.
// The input register holds a final byte only while the result register is full and stalled.
// Reset (synchronous, active low) clears the frame state, the sensor mask and both
// valid flags, and loads the register defaults.
module rfid_reply_frame_checker_top #(
    parameter int MAX_FRAME_BYTES = rfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rfc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic [7:0]                      o_cmd_code,
    output logic [7:0]                      o_uid_length,
    output logic [7:0]                      o_tag_value,
    output logic [7:0]                      o_sensor_value,
    output logic [7:0]                      o_sensor_mask
);
    import rfc_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       step;
    logic       in_xfer;
    t_result    core_result;
    t_result    out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_code        <= 8'd0;
            r_cfg.tag_command_code     <= 8'd2;
            r_cfg.version_command_code <= 8'd1;
            r_cfg.size_offset          <= 8'd3;
        end else if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_PREAMBLE: r_cfg.preamble_code        <= i_cfg_wdata;
                REG_TAG_CMD:  r_cfg.tag_command_code     <= i_cfg_wdata;
                REG_VER_CMD:  r_cfg.version_command_code <= i_cfg_wdata;
                REG_SIZE_OFS: r_cfg.size_offset          <= i_cfg_wdata;
                default:      r_cfg                      <= r_cfg;
            endcase
        end
    end

    // A middle byte never waits; a final byte waits for room in the result register.
    assign step       = r_in_valid && !(r_in_last && o_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_last_byte;
        end
    end

    rfc_frame_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    rfc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && r_in_last),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_status       = out_result.status;
    assign o_cmd_code     = out_result.cmd_code;
    assign o_uid_length   = out_result.uid_length;
    assign o_tag_value    = out_result.tag_value;
    assign o_sensor_value = out_result.sensor_value;
    assign o_sensor_mask  = out_result.sensor_mask;

endmodule

@@ sv/rfc_checker.sv @@
module rfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic [7:0] o_cmd_code,
    input logic [7:0] o_uid_length,
    input logic [7:0] o_tag_value,
    input logic [7:0] o_sensor_value,
    input logic [7:0] o_sensor_mask
);
    import rfc_pkg::*;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= 3'(ST_CRC)))
        else $error("status code out of range");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != 3'(ST_OK)) |->
            (o_cmd_code == 8'd0 && o_uid_length == 8'd0 &&
             o_tag_value == 8'd0 && o_sensor_value == 8'd0))
        else $error("failed frame reports header fields");

    a_mask_low_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sensor_mask[3:0] == 4'h0))
        else $error("sensor mask low nibble set");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_sensor_mask)))
        else $error("stalled result changed");

endmodule

bind rfid_reply_frame_checker_top rfc_checker u_rfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_cmd_code     (o_cmd_code),
    .o_uid_length   (o_uid_length),
    .o_tag_value    (o_tag_value),
    .o_sensor_value (o_sensor_value),
    .o_sensor_mask  (o_sensor_mask)
);
